// ----- design/crc8pr_pkg.sv -----
`default_nettype none

package crc8pr_pkg;

    // fixed field widths
    localparam int ACTION_W = 2;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 4;
    localparam int POS_W    = 16;
    localparam int LEN_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // parameter defaults
    localparam int BUFFER_BYTES_DEF       = 512;
    localparam int CRC_POLY_REFLECTED_DEF = 140;

    // header layout
    localparam int HEADER_BYTES = 6;
    localparam logic [POS_W-1:0] POS_DEST    = 16'd0;
    localparam logic [POS_W-1:0] POS_SENDER  = 16'd3;
    localparam logic [POS_W-1:0] POS_LEN_LO  = 16'd4;
    localparam logic [POS_W-1:0] POS_LEN_HI  = 16'd5;
    localparam logic [POS_W-1:0] POS_HDR_CRC = 16'd6;
    localparam logic [POS_W-1:0] POS_BODY    = 16'd7;
    localparam logic [LEN_W-1:0] SHORT_LEN   = 16'd8;

    // register reset values
    localparam logic [BYTE_W-1:0] UNIT_CODE_RST  = 8'h10;
    localparam logic [LEN_W-1:0]  MIN_LENGTH_RST = 16'd10;
    localparam logic [BYTE_W-1:0] END_MARKER_RST = 8'h04;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_UNIT_CODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_MARKER = 2'd2;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_DATA    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_START   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NOP     = 2'd3;

    typedef enum logic [STATUS_W-1:0] {
        ST_IGNORED  = 4'd0,
        ST_HDR_BYTE = 4'd1,
        ST_HDR_OK   = 4'd2,
        ST_HDR_BAD  = 4'd3,
        ST_BAD_LEN  = 4'd4,
        ST_BODY     = 4'd5,
        ST_PKT_OK   = 4'd6,
        ST_BAD_END  = 4'd7,
        ST_BAD_CRC  = 4'd8
    } status_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_HEADER = 2'd1,
        PH_BODY   = 2'd2,
        PH_HELD   = 2'd3
    } phase_t;

    // one byte folded into a reflected crc-8, lsb first
    function automatic logic [BYTE_W-1:0] crc8_fold(
        input logic [BYTE_W-1:0] crc,
        input logic [BYTE_W-1:0] b,
        input logic [BYTE_W-1:0] poly
    );
        logic [BYTE_W-1:0] v;
        v = crc ^ b;
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (v[0])
                v = (v >> 1) ^ poly;
            else
                v = v >> 1;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- design/crc8pr_in_if.sv -----
`default_nettype none

interface crc8pr_in_if
    import crc8pr_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [BYTE_W-1:0]   data_byte;

    modport source (output valid, output action, output data_byte, input ready);
    modport sink   (input valid, input action, input data_byte, output ready);
endinterface

`default_nettype wire

// ----- design/crc8pr_out_if.sv -----
`default_nettype none

interface crc8pr_out_if
    import crc8pr_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    byte_position;
    logic [BYTE_W-1:0]   byte_value;
    logic [LEN_W-1:0]    packet_length;
    logic [BYTE_W-1:0]   sender_address;

    modport source (output valid, output status, output byte_position, output byte_value,
                    output packet_length, output sender_address, input ready);
    modport sink   (input valid, input status, input byte_position, input byte_value,
                    input packet_length, input sender_address, output ready);
endinterface

`default_nettype wire

// ----- design/crc8_packet_receiver_unit.sv -----
// an accepted input beat shows its result beat on the output in the cycle after it is accepted
// throughput: one beat per cycle unless the output stalls, set by the single crc-8 fold
// and header compares between the frame state registers and the result register
// the input is ready whenever the result register is empty or is being emptied
// reset (rst_n low, asynchronous): idle phase, frame state cleared, result empty,
// registers back to unit code 0x10, minimum length 10, end marker 0x04
`default_nettype none

module crc8_packet_receiver_unit
    import crc8pr_pkg::*;
#(
    parameter int BUFFER_BYTES       = BUFFER_BYTES_DEF,
    parameter int CRC_POLY_REFLECTED = CRC_POLY_REFLECTED_DEF
)(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    crc8pr_in_if.sink                  rx,
    crc8pr_out_if.source               res,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // length must stay below the buffer minus the header bytes
    localparam logic [LEN_W:0]    LEN_LIMIT = (LEN_W+1)'(BUFFER_BYTES - HEADER_BYTES);
    localparam logic [BYTE_W-1:0] POLY      = BYTE_W'(CRC_POLY_REFLECTED);

    // configuration registers
    logic [BYTE_W-1:0] unit_code_reg;
    logic [LEN_W-1:0]  min_length_reg;
    logic [BYTE_W-1:0] end_marker_reg;

    // frame state
    phase_t            phase_reg, phase_next;
    logic [POS_W-1:0]  position_reg, position_next;
    logic [LEN_W-1:0]  length_reg, length_next;
    logic [BYTE_W-1:0] crc_reg, crc_next;
    logic              unit_match_reg, unit_match_next;
    logic [BYTE_W-1:0] sender_reg, sender_next;
    logic [BYTE_W-1:0] length_low_reg, length_low_next;

    // result register
    logic              out_valid_reg;
    status_t           status_reg, status_next;
    logic [POS_W-1:0]  bpos_reg, bpos_next;
    logic [BYTE_W-1:0] bval_reg, bval_next;
    logic [LEN_W-1:0]  plen_reg, plen_next;
    logic [BYTE_W-1:0] snd_reg, snd_next;

    logic              in_fire;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] crc_fold_val;
    logic              in_header_bytes;
    logic              hdr_bad;
    logic              len_bad;
    logic              last_byte;
    logic              crc_byte;
    logic              end_bad;
    logic              is_data;

    // the result register parts the two sides: a new beat enters while the
    // waiting one leaves
    assign rx.ready = !out_valid_reg || res.ready;
    assign in_fire  = rx.valid && rx.ready;
    assign b        = rx.data_byte;
    assign is_data  = (rx.action == ACT_DATA);

    assign crc_fold_val    = crc8_fold(crc_reg, b, POLY);
    assign in_header_bytes = (position_reg < POS_W'(HEADER_BYTES));
    // checksum byte against the running crc, and the destination match
    assign hdr_bad   = (crc_reg != b) || !unit_match_reg;
    assign len_bad   = ({1'b0, length_reg} >= LEN_LIMIT) || (length_reg < min_length_reg);
    // body: the last byte closes the packet, the one before it is the checksum
    assign last_byte = ({1'b0, position_reg} + 17'd1) >= {1'b0, length_reg};
    assign crc_byte  = ({1'b0, position_reg} + 17'd2) == {1'b0, length_reg};
    assign end_bad   = (b != end_marker_reg);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        case (rx.action)
            ACT_START:
            begin
                if (phase_reg != PH_HELD)
                    phase_next = PH_HEADER;
            end
            ACT_RELEASE:
            begin
                if (phase_reg == PH_HELD)
                    phase_next = PH_IDLE;
            end
            ACT_DATA:
            begin
                unique case (phase_reg) inside
                    PH_HEADER:
                    begin
                        if (!in_header_bytes)
                        begin
                            if (hdr_bad || len_bad)
                                phase_next = PH_IDLE;
                            else
                                phase_next = PH_BODY;
                        end
                    end
                    PH_BODY:
                    begin
                        if (last_byte)
                        begin
                            if (end_bad || crc_reg != '0)
                                phase_next = PH_IDLE;
                            else
                                phase_next = PH_HELD;
                        end
                    end
                    PH_IDLE, PH_HELD:
                        phase_next = phase_reg;
                    default:
                        phase_next = phase_reg;
                endcase
            end
            default:
                phase_next = phase_reg;
        endcase
    end

    // frame datapath and result fields
    always_comb
    begin
        position_next   = position_reg;
        length_next     = length_reg;
        crc_next        = crc_reg;
        unit_match_next = unit_match_reg;
        sender_next     = sender_reg;
        length_low_next = length_low_reg;
        status_next     = ST_IGNORED;
        bpos_next       = '0;
        bval_next       = '0;
        plen_next       = '0;
        snd_next        = '0;

        if (rx.action == ACT_START && phase_reg != PH_HELD)
        begin
            position_next   = '0;
            length_next     = '0;
            crc_next        = '0;
            unit_match_next = 1'b0;
            sender_next     = '0;
            length_low_next = '0;
        end
        else if (is_data && phase_reg == PH_HEADER)
        begin
            bpos_next = position_reg;
            bval_next = b;
            if (in_header_bytes)
            begin
                status_next = ST_HDR_BYTE;
                if (position_reg == POS_DEST)
                    unit_match_next = (b == unit_code_reg);
                if (position_reg == POS_SENDER)
                    sender_next = b;
                if (position_reg == POS_LEN_LO)
                    length_low_next = b;
                if (position_reg == POS_LEN_HI)
                    length_next = {b, length_low_reg};
                crc_next      = crc_fold_val;
                position_next = position_reg + 16'd1;
            end
            else
            begin
                plen_next = length_reg;
                if (hdr_bad)
                    status_next = ST_HDR_BAD;
                else if (len_bad)
                    status_next = ST_BAD_LEN;
                else
                begin
                    status_next = ST_HDR_OK;
                    // short packet: byte 7 is already the last, so the checksum
                    // byte is cancelled rather than folded
                    if (length_reg <= SHORT_LEN)
                        crc_next = crc_reg ^ b;
                    else
                        crc_next = crc_fold_val;
                    position_next = POS_BODY;
                end
            end
        end
        else if (is_data && phase_reg == PH_BODY)
        begin
            bpos_next = position_reg;
            bval_next = b;
            plen_next = length_reg;
            if (last_byte)
            begin
                if (end_bad)
                    status_next = ST_BAD_END;
                else if (crc_reg != '0)
                    status_next = ST_BAD_CRC;
                else
                begin
                    status_next = ST_PKT_OK;
                    snd_next    = sender_reg;
                end
            end
            else
            begin
                status_next = ST_BODY;
                // the trailing checksum cancels the crc to zero on a good packet
                if (crc_byte)
                    crc_next = crc_reg ^ b;
                else
                    crc_next = crc_fold_val;
                position_next = position_reg + 16'd1;
            end
        end

        // ignored beats still report the length while a packet is open or held
        if (status_next == ST_IGNORED && (phase_next == PH_BODY || phase_next == PH_HELD))
            plen_next = length_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_code_reg  <= UNIT_CODE_RST;
            min_length_reg <= MIN_LENGTH_RST;
            end_marker_reg <= END_MARKER_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_UNIT_CODE:  unit_code_reg  <= cfg_data[BYTE_W-1:0];
                REG_MIN_LENGTH: min_length_reg <= cfg_data[LEN_W-1:0];
                REG_END_MARKER: end_marker_reg <= cfg_data[BYTE_W-1:0];
                default:        ;
            endcase
        end
    end

    // frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            position_reg   <= '0;
            length_reg     <= '0;
            crc_reg        <= '0;
            unit_match_reg <= 1'b0;
            sender_reg     <= '0;
            length_low_reg <= '0;
        end
        else if (in_fire)
        begin
            phase_reg      <= phase_next;
            position_reg   <= position_next;
            length_reg     <= length_next;
            crc_reg        <= crc_next;
            unit_match_reg <= unit_match_next;
            sender_reg     <= sender_next;
            length_low_reg <= length_low_next;
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire)
            out_valid_reg <= 1'b1;
        else if (res.ready)
            out_valid_reg <= 1'b0;
    end

    // result payload, loaded with each accepted beat
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            status_reg <= status_next;
            bpos_reg   <= bpos_next;
            bval_reg   <= bval_next;
            plen_reg   <= plen_next;
            snd_reg    <= snd_next;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.status         = status_reg;
    assign res.byte_position  = bpos_reg;
    assign res.byte_value     = bval_reg;
    assign res.packet_length  = plen_reg;
    assign res.sender_address = snd_reg;

endmodule

`default_nettype wire

// ----- design/crc8pr_checker.sv -----
`default_nettype none

module crc8pr_checker
    import crc8pr_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire logic [STATUS_W-1:0] status,
    input wire logic [POS_W-1:0]    byte_position,
    input wire logic [BYTE_W-1:0]   byte_value,
    input wire logic [LEN_W-1:0]    packet_length,
    input wire logic [BYTE_W-1:0]   sender_address
);

    // a stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(byte_position)
                                     && $stable(byte_value) && $stable(packet_length))
        else $error("result beat changed while stalled");

    // status code within the defined set
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ST_BAD_CRC)
        else $error("undefined status code");

    // ignored beats carry no byte and no sender
    a_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_IGNORED |->
            byte_position == '0 && byte_value == '0 && sender_address == '0)
        else $error("ignored beat carries byte data");

    // sender only reported on a good packet
    a_sender: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_PKT_OK |-> sender_address == '0)
        else $error("sender reported without a good packet");

    // header bytes sit below the checksum and carry no length yet
    a_header: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_HDR_BYTE |->
            byte_position < POS_HDR_CRC && packet_length == '0)
        else $error("header byte out of place");

endmodule

bind crc8_packet_receiver_unit crc8pr_checker u_crc8pr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (res.valid),
    .out_ready      (res.ready),
    .status         (res.status),
    .byte_position  (res.byte_position),
    .byte_value     (res.byte_value),
    .packet_length  (res.packet_length),
    .sender_address (res.sender_address)
);

`default_nettype wire

// ----- test/tb.sv -----
`default_nettype none

import crc8pr_pkg::*;

// reflected dallas/maxim polynomial, initial value zero, no final xor
localparam logic [BYTE_W-1:0] MAXIM_POLY = 8'(CRC_POLY_REFLECTED_DEF);
// largest header length that still fits the buffer
localparam int LONGEST_LEN = BUFFER_BYTES_DEF - HEADER_BYTES - 1;

typedef struct packed {
    status_t           status;
    logic [POS_W-1:0]  position;
    logic [BYTE_W-1:0] value;
    logic [LEN_W-1:0]  length;
    logic [BYTE_W-1:0] sender;
} verdict_t;

typedef enum int {
    FLAW_NONE,
    FLAW_UNIT,
    FLAW_HDR_CRC,
    FLAW_END,
    FLAW_BODY,
    FLAW_CUT
} frame_flaw_t;

function automatic logic [BYTE_W-1:0] maxim_crc_step(logic [BYTE_W-1:0] crc,
                                                     logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] v;
    v = crc ^ b;
    repeat (BYTE_W) v = v[0] ? ((v >> 1) ^ MAXIM_POLY) : (v >> 1);
    return v;
endfunction

class deframer_tracker;
    logic [BYTE_W-1:0] unit_code;
    logic [LEN_W-1:0]  min_length;
    logic [BYTE_W-1:0] end_marker;

    phase_t            phase;
    logic [POS_W-1:0]  pos;
    logic [LEN_W-1:0]  hdr_len;
    logic [BYTE_W-1:0] crc;
    logic              dest_ok;
    logic [BYTE_W-1:0] src;
    logic [BYTE_W-1:0] len_low;

    verdict_t          awaited_results[$];
    int unsigned       errors;

    function new();
        unit_code  = UNIT_CODE_RST;
        min_length = MIN_LENGTH_RST;
        end_marker = END_MARKER_RST;
        phase      = PH_IDLE;
        pos        = '0;
        hdr_len    = '0;
        crc        = '0;
        dest_ok    = 1'b0;
        src        = '0;
        len_low    = '0;
        errors     = 0;
    endfunction

    function int pending();
        return awaited_results.size();
    endfunction

    // one accepted input beat gives exactly one result beat
    function void note_beat(logic [ACTION_W-1:0] act, logic [BYTE_W-1:0] b);
        verdict_t v;
        v = '0;
        v.status = ST_IGNORED;
        if (act == ACT_START)
        begin
            if (phase != PH_HELD)
            begin
                phase   = PH_HEADER;
                pos     = '0;
                hdr_len = '0;
                crc     = '0;
                dest_ok = 1'b0;
                src     = '0;
                len_low = '0;
            end
        end
        else if (act == ACT_RELEASE)
        begin
            if (phase == PH_HELD)
                phase = PH_IDLE;
        end
        else if (act == ACT_DATA && phase == PH_HEADER)
        begin
            v.position = pos;
            v.value    = b;
            if (pos < POS_W'(HEADER_BYTES))
            begin
                v.status = ST_HDR_BYTE;
                if (pos == POS_DEST)
                    dest_ok = (b == unit_code);
                if (pos == POS_SENDER)
                    src = b;
                if (pos == POS_LEN_LO)
                    len_low = b;
                if (pos == POS_LEN_HI)
                    hdr_len = {b, len_low};
                crc = maxim_crc_step(crc, b);
                pos = pos + 16'd1;
            end
            else
            begin
                v.length = hdr_len;
                if (crc != b || !dest_ok)
                begin
                    v.status = ST_HDR_BAD;
                    phase    = PH_IDLE;
                end
                else if (int'(hdr_len) >= BUFFER_BYTES_DEF - HEADER_BYTES ||
                         hdr_len < min_length)
                begin
                    v.status = ST_BAD_LEN;
                    phase    = PH_IDLE;
                end
                else
                begin
                    v.status = ST_HDR_OK;
                    phase    = PH_BODY;
                    crc      = (hdr_len <= SHORT_LEN) ? (crc ^ b) : maxim_crc_step(crc, b);
                    pos      = POS_BODY;
                end
            end
        end
        else if (act == ACT_DATA && phase == PH_BODY)
        begin
            v.position = pos;
            v.value    = b;
            v.length   = hdr_len;
            if (int'(pos) + 1 >= int'(hdr_len))
            begin
                if (b != end_marker)
                begin
                    v.status = ST_BAD_END;
                    phase    = PH_IDLE;
                end
                else if (crc != '0)
                begin
                    v.status = ST_BAD_CRC;
                    phase    = PH_IDLE;
                end
                else
                begin
                    v.status = ST_PKT_OK;
                    v.sender = src;
                    phase    = PH_HELD;
                end
            end
            else
            begin
                v.status = ST_BODY;
                // the checksum byte cancels the running crc instead of being folded
                if (int'(pos) + 2 == int'(hdr_len))
                    crc = crc ^ b;
                else
                    crc = maxim_crc_step(crc, b);
                pos = pos + 16'd1;
            end
        end
        if (v.status == ST_IGNORED && (phase == PH_BODY || phase == PH_HELD))
            v.length = hdr_len;
        awaited_results.push_back(v);
    endfunction

    function void compare_field(string name, logic [LEN_W-1:0] want, logic [LEN_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    function void check_result(verdict_t got);
        verdict_t want;
        if (awaited_results.size() == 0)
        begin
            $display("%0t: unexpected result beat: expected none, actual status %0d",
                     $time, got.status);
            errors++;
            return;
        end
        want = awaited_results.pop_front();
        compare_field("status", LEN_W'(want.status), LEN_W'(got.status));
        compare_field("byte_position", want.position, got.position);
        compare_field("byte_value", LEN_W'(want.value), LEN_W'(got.value));
        compare_field("packet_length", want.length, got.length);
        compare_field("sender_address", LEN_W'(want.sender), LEN_W'(got.sender));
    endfunction
endclass

module tb;
    import crc8pr_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    crc8pr_in_if  rx();
    crc8pr_out_if res();

    crc8_packet_receiver_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    deframer_tracker tracker;

    // idling odds in percent, per side
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;

    // long receiver hold-off, requested by the stimulus and counted by the receiver
    int unsigned hold_reqs  = 0;
    int unsigned holds_done = 0;
    int unsigned hold_left  = 0;

    // beats sent inside frames, the ones that drive the deframer forward
    int unsigned framed_beats;

    verdict_t seen;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop in case the handshake hangs
    initial
    begin
        #5_000_000;
        $display("%0t: timeout, result beats still awaited", $time);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // receiver side: random back-pressure plus the occasional long hold-off
    initial
    begin
        res.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left != 0)
            begin
                hold_left--;
                res.ready <= 1'b0;
            end
            else if (hold_reqs != holds_done)
            begin
                holds_done++;
                hold_left = 60;
                res.ready <= 1'b0;
            end
            else
                res.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // result beats are sampled at the rising edge, before the block updates them
    always @(posedge clk)
    begin
        if (rst_n && res.valid && res.ready)
        begin
            seen.status   = status_t'(res.status);
            seen.position = res.byte_position;
            seen.value    = res.byte_value;
            seen.length   = res.packet_length;
            seen.sender   = res.sender_address;
            tracker.check_result(seen);
        end
    end

    // entered and left at a falling edge; valid stays up for a back-to-back beat
    task automatic send_beat(logic [ACTION_W-1:0] act, logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            rx.valid <= 1'b0;
            @(negedge clk);
        end
        rx.valid     <= 1'b1;
        rx.action    <= act;
        rx.data_byte <= b;
        do
            @(posedge clk);
        while (!rx.ready);
        tracker.note_beat(act, b);
        @(negedge clk);
    endtask

    // sender stops and waits until every awaited result beat has come back
    task automatic wait_drained();
        rx.valid <= 1'b0;
        while (tracker.pending() != 0)
            @(negedge clk);
        // a little margin on top
        repeat (2) @(negedge clk);
    endtask

    // only called with no result beat pending; all three registers every time
    task automatic load_registers(logic [BYTE_W-1:0] unit, logic [LEN_W-1:0] min_len,
                                  logic [BYTE_W-1:0] marker);
        cfg_we    <= 1'b1;
        cfg_index <= REG_UNIT_CODE;
        cfg_data  <= CFG_DATA_W'(unit);
        @(negedge clk);
        cfg_index <= REG_MIN_LENGTH;
        cfg_data  <= min_len;
        @(negedge clk);
        cfg_index <= REG_END_MARKER;
        cfg_data  <= CFG_DATA_W'(marker);
        @(negedge clk);
        cfg_we <= 1'b0;
        tracker.unit_code  = unit;
        tracker.min_length = min_len;
        tracker.end_marker = marker;
    endtask

    // builds a frame for the current register settings, then damages it as asked
    task automatic send_frame(logic [LEN_W-1:0] len, frame_flaw_t flaw);
        logic [BYTE_W-1:0] frame[$];
        logic [BYTE_W-1:0] crc;
        int unsigned       total;
        int unsigned       stop;
        frame = {};
        frame.push_back(flaw == FLAW_UNIT ? tracker.unit_code ^ 8'($urandom_range(255, 1))
                                          : tracker.unit_code);
        repeat (3) frame.push_back(8'($urandom));
        frame.push_back(len[7:0]);
        frame.push_back(len[15:8]);
        crc = '0;
        foreach (frame[i])
            crc = maxim_crc_step(crc, frame[i]);
        frame.push_back(crc);

        // a rejected length ends the frame at the header checksum
        if (len < tracker.min_length || int'(len) > LONGEST_LEN)
            total = HEADER_BYTES + 1;
        else if (len <= SHORT_LEN)
            total = 8;
        else
            total = len;

        if (total >= 9)
        begin
            crc = maxim_crc_step(crc, frame[HEADER_BYTES]);
            for (int i = 7; i <= int'(total) - 3; i++)
            begin
                frame.push_back(8'($urandom));
                crc = maxim_crc_step(crc, frame[i]);
            end
            frame.push_back(crc);
        end
        if (total >= 8)
            frame.push_back(tracker.end_marker);

        case (flaw)
            FLAW_HDR_CRC: frame[HEADER_BYTES] ^= 8'($urandom_range(255, 1));
            FLAW_END:     frame[total-1] ^= 8'($urandom_range(255, 1));
            FLAW_BODY:
            begin
                if (total >= 9)
                    frame[$urandom_range(total - 2, 7)] ^= 8'($urandom_range(255, 1));
            end
            default:;
        endcase

        // a cut frame is left hanging, the next start restarts reception
        stop = (flaw == FLAW_CUT) ? $urandom_range(total - 1) : total;
        send_beat(ACT_START, 8'($urandom));
        for (int i = 0; i < int'(stop); i++)
            send_beat(ACT_DATA, frame[i]);
        framed_beats += stop + 1;
    endtask

    function automatic logic [LEN_W-1:0] pick_length();
        int unsigned r;
        int unsigned lo;
        int unsigned hi;
        r  = $urandom_range(99);
        lo = 32'(tracker.min_length);
        if (lo > LONGEST_LEN || r < 5)
            return LEN_W'($urandom_range(65535));
        if (r < 8)
            return LEN_W'(LONGEST_LEN + $urandom_range(1));
        if (r < 11 && lo > 0)
            return LEN_W'(lo - 1);
        if (r < 13)
            return LEN_W'($urandom_range(LONGEST_LEN, lo));
        if (lo <= SHORT_LEN && r < 30)
            return LEN_W'($urandom_range(SHORT_LEN, lo));
        hi = (lo + 24 > LONGEST_LEN) ? LONGEST_LEN : lo + 24;
        return LEN_W'($urandom_range(hi, lo));
    endfunction

    function automatic frame_flaw_t pick_flaw();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55)
            return FLAW_NONE;
        if (r < 63)
            return FLAW_UNIT;
        if (r < 71)
            return FLAW_HDR_CRC;
        if (r < 79)
            return FLAW_END;
        if (r < 89)
            return FLAW_BODY;
        return FLAW_CUT;
    endfunction

    // mostly well-formed frames with random content, some damaged, some noise
    task automatic run_traffic(int unsigned budget);
        framed_beats = 0;
        while (framed_beats < budget)
        begin
            if ($urandom_range(99) < 82)
            begin
                send_frame(pick_length(), pick_flaw());
                if ($urandom_range(99) < 85)
                    send_beat(ACT_RELEASE, 8'($urandom));
            end
            else
            begin
                repeat ($urandom_range(3, 1))
                    send_beat(ACT_LEN_W_NOISE(), 8'($urandom));
            end
            // sender occasionally waits for the block to empty completely
            if ($urandom_range(99) < 3)
                wait_drained();
        end
    endtask

    function automatic logic [ACTION_W-1:0] ACT_LEN_W_NOISE();
        return ACTION_W'($urandom_range(3));
    endfunction

    initial
    begin
        int unsigned stage;
        rst_n        = 1'b0;
        rx.valid     = 1'b0;
        rx.action    = ACT_NOP;
        rx.data_byte = '0;
        cfg_we       = 1'b0;
        cfg_index    = REG_UNIT_CODE;
        cfg_data     = '0;
        tracker      = new();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: idle-time noise, one good frame on the reset registers
        send_beat(ACT_NOP, 8'hA5);
        send_beat(ACT_RELEASE, 8'h00);
        send_beat(ACT_DATA, 8'hFF);
        send_frame(MIN_LENGTH_RST, FLAW_NONE);
        // held frame ignores a start and data until it is released
        send_beat(ACT_START, 8'h00);
        send_beat(ACT_DATA, 8'h00);
        send_beat(ACT_RELEASE, 8'hFF);
        wait_drained();

        // short length: byte 7 is the last byte, header crc doubles as packet crc
        load_registers(8'h00, 16'd0, 8'hFF);
        send_frame(16'd0, FLAW_NONE);
        send_beat(ACT_RELEASE, 8'h00);

        // random part, three idling patterns, two register settings each
        for (stage = 0; stage < 6; stage++)
        begin
            wait_drained();
            case (stage / 2)
                0:
                begin
                    tx_idle_pct = 8;
                    rx_idle_pct <= 79;
                end
                1:
                begin
                    tx_idle_pct = 79;
                    rx_idle_pct <= 8;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct <= 0;
                end
            endcase
            case (stage)
                0:       load_registers(8'hFF, 16'd9, 8'h00);
                1:       load_registers(8'($urandom), 16'd0, 8'hFF);
                2:       load_registers(8'h00, 16'hFFFF, 8'($urandom));
                3:       load_registers(UNIT_CODE_RST, MIN_LENGTH_RST, END_MARKER_RST);
                4:       load_registers(8'($urandom), LEN_W'($urandom_range(40)), 8'($urandom));
                default: load_registers(8'h80, 16'd1, 8'h7F);
            endcase
            // long receiver stall while frames keep coming, so the input backs up
            if (stage == 1 || stage == 4)
                hold_reqs++;
            run_traffic(stage == 2 ? 100 : 190);
        end

        wait_drained();
        repeat (4) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

`default_nettype wire
